/* rtl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/mia_pkg.sv */
// shared types and constants for the integer alu
`default_nettype none
package mia_pkg;
    localparam int unsigned XLEN = 32;
    localparam int unsigned CMD_W = 5;
    localparam int unsigned IMM_W = 16;
    localparam int unsigned QDEPTH = 2;

    typedef enum logic [4:0] {
        CMD_ADD = 5'd0, CMD_SUB = 5'd1, CMD_MULT = 5'd2, CMD_DIV = 5'd3,
        CMD_AND = 5'd4, CMD_OR = 5'd5, CMD_XOR = 5'd6, CMD_NOR = 5'd7,
        CMD_SLT = 5'd8, CMD_SLL = 5'd9, CMD_SRL = 5'd10, CMD_SRA = 5'd11,
        CMD_LUI = 5'd12, CMD_ADDI = 5'd13, CMD_SLTI = 5'd14, CMD_SLTIU = 5'd15,
        CMD_ANDI = 5'd16, CMD_ORI = 5'd17, CMD_XORI = 5'd18
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_ALU  = 2'd0,
        KIND_MULT = 2'd1,
        KIND_DIV  = 2'd2,
        KIND_NOP  = 2'd3
    } kind_t;

    // classified item handed from front to back
    typedef struct packed {
        kind_t             kind;
        logic [XLEN-1:0]   result;
        logic [XLEN-1:0]   operand_a;
        logic [XLEN-1:0]   operand_b;
    } work_t;

    typedef struct packed {
        logic [XLEN-1:0] result;
        logic [XLEN-1:0] hi_value;
        logic [XLEN-1:0] lo_value;
        logic            divide_by_zero;
    } res_t;
endpackage
`default_nettype wire

/* rtl/mia_front.sv */
// front end: accepts items, computes single-cycle ops, classifies mult and div
`default_nettype none
module mia_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [mia_pkg::CMD_W-1:0]     cmd,
    input  wire logic [mia_pkg::XLEN-1:0]      a,
    input  wire logic [mia_pkg::XLEN-1:0]      b,
    input  wire logic [mia_pkg::IMM_W-1:0]     imm,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output mia_pkg::work_t                     out_work
);
    logic                 valid_reg;
    mia_pkg::work_t       work_reg;
    mia_pkg::work_t       work_next;
    logic [31:0]          simm;
    logic [31:0]          zimm;
    logic [4:0]           sh;

    assign simm = {{16{imm[15]}}, imm};
    assign zimm = {16'd0, imm};
    assign sh   = b[4:0];

    always_comb begin
        work_next.kind      = mia_pkg::KIND_ALU;
        work_next.result    = '0;
        work_next.operand_a = a;
        work_next.operand_b = b;
        unique case (cmd)
            mia_pkg::CMD_ADD:   work_next.result = a + b;
            mia_pkg::CMD_SUB:   work_next.result = a - b;
            mia_pkg::CMD_MULT:  work_next.kind = mia_pkg::KIND_MULT;
            mia_pkg::CMD_DIV:   work_next.kind = mia_pkg::KIND_DIV;
            mia_pkg::CMD_AND:   work_next.result = a & b;
            mia_pkg::CMD_OR:    work_next.result = a | b;
            mia_pkg::CMD_XOR:   work_next.result = a ^ b;
            mia_pkg::CMD_NOR:   work_next.result = ~(a | b);
            mia_pkg::CMD_SLT:   work_next.result = {31'd0, $signed(a) < $signed(b)};
            mia_pkg::CMD_SLL:   work_next.result = a << sh;
            mia_pkg::CMD_SRL:   work_next.result = a >> sh;
            mia_pkg::CMD_SRA:   work_next.result = $unsigned($signed(a) >>> sh);
            mia_pkg::CMD_LUI:   work_next.result = {imm, 16'd0};
            mia_pkg::CMD_ADDI:  work_next.result = a + simm;
            mia_pkg::CMD_SLTI:  work_next.result = {31'd0, $signed(a) < $signed(simm)};
            mia_pkg::CMD_SLTIU: work_next.result = {31'd0, a < simm};
            mia_pkg::CMD_ANDI:  work_next.result = a & zimm;
            mia_pkg::CMD_ORI:   work_next.result = a | zimm;
            mia_pkg::CMD_XORI:  work_next.result = a ^ zimm;
            default:            work_next.kind = mia_pkg::KIND_NOP;
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_work  = work_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            work_reg <= work_next;
        end
    end
endmodule
`default_nettype wire

/* rtl/mia_queue.sv */
// short fifo between front and back
`default_nettype none
module mia_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire mia_pkg::work_t   in_work,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output mia_pkg::work_t        out_work
);
    mia_pkg::work_t   mem_reg [mia_pkg::QDEPTH];
    logic             wptr_reg;
    logic             rptr_reg;
    logic [1:0]       count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != 2'(mia_pkg::QDEPTH);
    assign out_valid = count_reg != 2'd0;
    assign out_work  = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) wptr_reg <= !wptr_reg;
            if (pop)  rptr_reg <= !rptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
        if (push) begin
            mem_reg[wptr_reg] <= in_work;
        end
    end
endmodule
`default_nettype wire

/* rtl/mia_back.sv */
// back end: holds hi/lo, runs multi-cycle mult and radix-2 divide
`default_nettype none
module mia_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire mia_pkg::work_t   in_work,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output mia_pkg::res_t         out_res
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL1, ST_MUL2, ST_DIV, ST_DFIX, ST_OUT
    } state_t;

    state_t          state_reg;
    logic [31:0]     hi_reg;
    logic [31:0]     lo_reg;
    logic [31:0]     res_reg;
    logic            dz_reg;
    logic            na_reg;
    logic            nb_reg;
    logic [31:0]     ma_reg;
    logic [31:0]     mb_reg;
    logic [31:0]     rem_reg;
    logic [31:0]     quo_reg;
    logic [4:0]      cnt_reg;
    logic [63:0]     pll_reg;
    logic [63:0]     plh_reg;
    logic [63:0]     phl_reg;
    logic [63:0]     phh_reg;
    logic [63:0]     prod;
    logic [63:0]     sprod;
    logic [32:0]     rtrial;
    logic [32:0]     rsub;

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = state_reg == ST_OUT;
    assign out_res   = '{result: res_reg, hi_value: hi_reg, lo_value: lo_reg,
                         divide_by_zero: dz_reg};

    // magnitude product from 16x16 partials, sign applied after
    assign prod  = pll_reg + (plh_reg << 16) + (phl_reg << 16) + (phh_reg << 32);
    assign sprod = (na_reg != nb_reg) ? (64'd0 - prod) : prod;

    assign rtrial = {rem_reg, quo_reg[31]};
    assign rsub   = rtrial - {1'b0, mb_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            hi_reg    <= '0;
            lo_reg    <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        res_reg <= in_work.result;
                        dz_reg  <= 1'b0;
                        na_reg  <= in_work.operand_a[31];
                        nb_reg  <= in_work.operand_b[31];
                        ma_reg  <= in_work.operand_a[31] ? 32'd0 - in_work.operand_a
                                                         : in_work.operand_a;
                        mb_reg  <= in_work.operand_b[31] ? 32'd0 - in_work.operand_b
                                                         : in_work.operand_b;
                        unique case (in_work.kind)
                            mia_pkg::KIND_MULT: state_reg <= ST_MUL1;
                            mia_pkg::KIND_DIV: begin
                                if (in_work.operand_b == '0) begin
                                    dz_reg    <= 1'b1;
                                    state_reg <= ST_OUT;
                                end else begin
                                    state_reg <= ST_DIV;
                                end
                            end
                            default: state_reg <= ST_OUT;
                        endcase
                    end
                end
                ST_MUL1: begin
                    pll_reg   <= 64'(ma_reg[15:0] * mb_reg[15:0]);
                    plh_reg   <= 64'(ma_reg[15:0] * mb_reg[31:16]);
                    phl_reg   <= 64'(ma_reg[31:16] * mb_reg[15:0]);
                    phh_reg   <= 64'(ma_reg[31:16] * mb_reg[31:16]);
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    hi_reg    <= sprod[63:32];
                    lo_reg    <= sprod[31:0];
                    state_reg <= ST_OUT;
                end
                ST_DIV: begin
                    // quotient bits are stepped below
                end
                ST_DFIX: begin
                    lo_reg    <= (na_reg != nb_reg) ? 32'd0 - quo_reg : quo_reg;
                    hi_reg    <= na_reg ? 32'd0 - rem_reg : rem_reg;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
            // restoring divide, one quotient bit per cycle
            if (state_reg == ST_IDLE) begin
                cnt_reg <= 5'd0;
                rem_reg <= '0;
                quo_reg <= in_work.operand_a[31] ? 32'd0 - in_work.operand_a
                                                 : in_work.operand_a;
            end else if (state_reg == ST_DIV) begin
                if (rsub[32]) begin
                    rem_reg <= rtrial[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end else begin
                    rem_reg <= rsub[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) state_reg <= ST_DFIX;
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/mips_integer_alu_core.sv */
// top level of the mips32 integer alu with hi/lo
//
// one item in on the s_ channel, one item out on the m_ channel, in order.
// the front stage decodes cmd and computes every single-cycle operation in
// one registered step, then passes the item through a two-entry queue to the
// back end, which owns hi and lo.
// alu and unused codes pass the back end straight to the output;
// mult forms 16x16 partial products, then the sum and sign;
// div runs a restoring divider, one quotient bit per cycle, plus fixup;
// a zero divisor skips the divider and returns with divide_by_zero set.
// flow: the back end takes one item at a time and holds it until the
// result is taken; the front keeps accepting while the queue has room.
// reset: synchronous active-low aresetn clears hi, lo and all valid state.
// stall: when m_tready is low the result is held, the queue fills and then
// s_tready drops; nothing is lost.
`default_nettype none
`include "assert_macros.svh"
module mips_integer_alu_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // cmd[4:0], operand_a[36:5], operand_b[68:37], imm[84:69], zero pad
    input  wire logic [87:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // result[31:0], hi_value[63:32], lo_value[95:64], divide_by_zero[96], pad
    output logic [103:0]      m_tdata
);
    logic              f_valid;
    logic              f_ready;
    mia_pkg::work_t    f_work;
    logic              q_valid;
    logic              q_ready;
    mia_pkg::work_t    q_work;
    mia_pkg::res_t     res;

    mia_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .cmd(s_tdata[4:0]), .a(s_tdata[36:5]), .b(s_tdata[68:37]),
        .imm(s_tdata[84:69]),
        .out_valid(f_valid), .out_ready(f_ready), .out_work(f_work)
    );

    mia_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_work(f_work),
        .out_valid(q_valid), .out_ready(q_ready), .out_work(q_work)
    );

    mia_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ready(q_ready), .in_work(q_work),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tdata = {7'd0, res.divide_by_zero, res.lo_value, res.hi_value, res.result};

    // a result with a zero divisor flag never carries a nonzero register result
    `ASSERT_IMPL(a_dz_result, aclk, aresetn, m_tvalid && m_tdata[96], m_tdata[31:0] == 32'd0)
    // a stalled result keeps its data
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // the back end takes no new item while a result is pending
    `ASSERT_IMPL(a_one_at_a_time, aclk, aresetn, m_tvalid, !q_ready)
endmodule
`default_nettype wire

/* test/mips_integer_alu_core_test.sv */
// testbench for the mips32 integer alu with hi/lo: random and directed items, scoreboard check
`timescale 1ns / 1ps
`default_nettype none
module mips_integer_alu_core_test;

    // one expected output item of the alu
    typedef struct {
        logic [31:0] result;
        logic [31:0] hi_value;
        logic [31:0] lo_value;
        logic        divide_by_zero;
    } alu_out_t;

    // predicts each output from accepted items and keeps its own hi/lo copy
    class alu_scoreboard;
        logic [31:0] hi_copy;
        logic [31:0] lo_copy;
        alu_out_t pending[$];
        int errors;

        function new();
            hi_copy = '0;
            lo_copy = '0;
            errors = 0;
        endfunction

        function void note_item(logic [4:0] cmd, logic [31:0] a, logic [31:0] b,
                                logic [15:0] imm);
            alu_out_t e;
            logic [31:0] simm;
            logic [31:0] zimm;
            logic [4:0] sh;
            logic signed [63:0] prod;
            logic [31:0] ma, mb, q, r;
            simm = {{16{imm[15]}}, imm};
            zimm = {16'd0, imm};
            sh = b[4:0];
            e.result = '0;
            e.divide_by_zero = 1'b0;
            case (cmd)
                mia_pkg::CMD_ADD:   e.result = a + b;
                mia_pkg::CMD_SUB:   e.result = a - b;
                mia_pkg::CMD_MULT: begin
                    prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                    hi_copy = prod[63:32];
                    lo_copy = prod[31:0];
                end
                mia_pkg::CMD_DIV: begin
                    if (b == 0) begin
                        e.divide_by_zero = 1'b1;
                    end else begin
                        ma = a[31] ? -a : a;
                        mb = b[31] ? -b : b;
                        q = ma / mb;
                        r = ma % mb;
                        lo_copy = (a[31] != b[31]) ? -q : q;
                        hi_copy = a[31] ? -r : r;
                    end
                end
                mia_pkg::CMD_AND:   e.result = a & b;
                mia_pkg::CMD_OR:    e.result = a | b;
                mia_pkg::CMD_XOR:   e.result = a ^ b;
                mia_pkg::CMD_NOR:   e.result = ~(a | b);
                mia_pkg::CMD_SLT:   e.result = {31'd0, $signed(a) < $signed(b)};
                mia_pkg::CMD_SLL:   e.result = a << sh;
                mia_pkg::CMD_SRL:   e.result = a >> sh;
                mia_pkg::CMD_SRA:   e.result = $signed(a) >>> sh;
                mia_pkg::CMD_LUI:   e.result = {imm, 16'd0};
                mia_pkg::CMD_ADDI:  e.result = a + simm;
                mia_pkg::CMD_SLTI:  e.result = {31'd0, $signed(a) < $signed(simm)};
                mia_pkg::CMD_SLTIU: e.result = {31'd0, a < simm};
                mia_pkg::CMD_ANDI:  e.result = a & zimm;
                mia_pkg::CMD_ORI:   e.result = a | zimm;
                mia_pkg::CMD_XORI:  e.result = a ^ zimm;
                default: ;
            endcase
            e.hi_value = hi_copy;
            e.lo_value = lo_copy;
            pending.push_back(e);
        endfunction

        task check_result(logic [103:0] data);
            alu_out_t e;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected output item %h", data));
                return;
            end
            e = pending.pop_front();
            if (data[31:0] !== e.result)
                report_mismatch($sformatf("result %h, want %h", data[31:0], e.result));
            if (data[63:32] !== e.hi_value)
                report_mismatch($sformatf("hi %h, want %h", data[63:32], e.hi_value));
            if (data[95:64] !== e.lo_value)
                report_mismatch($sformatf("lo %h, want %h", data[95:64], e.lo_value));
            if (data[96] !== e.divide_by_zero)
                report_mismatch($sformatf("divide_by_zero %b, want %b", data[96],
                                          e.divide_by_zero));
        endtask

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [87:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;

    alu_scoreboard board;
    bit calm;          // no idling on either side while set

    mips_integer_alu_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // random 32-bit word biased toward edges
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 40);
            5: return -$urandom_range(1, 40);
            default: return $urandom;
        endcase
    endfunction

    // present one item and hold it until accepted
    task automatic send_item(logic [4:0] cmd, logic [31:0] a, logic [31:0] b,
                             logic [15:0] imm);
        while (!calm && $urandom_range(0, 99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'd0, imm, b, a, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_item(cmd, a, b, imm);
    endtask

    // receive side: random stalls, check each accepted output item
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) board.check_result(m_tdata);
            m_tready <= calm || ($urandom_range(0, 99) >= 6);
        end
    end

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int i;
        logic [4:0] c;
        board = new();
        calm = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: every operation and the special cases
        for (i = 0; i <= int'(mia_pkg::CMD_XORI); i++)
            send_item(i[4:0], 32'h8000_0001, 32'hFFFF_FFE3, 16'h8001);
        send_item(mia_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'd1, 16'h0);          // overflow wraps
        send_item(mia_pkg::CMD_DIV, 32'd5, 32'd0, 16'h7FFF);               // zero divisor
        send_item(mia_pkg::CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 16'h0);  // min over -1
        send_item(mia_pkg::CMD_MULT, 32'h8000_0000, 32'h8000_0000, 16'hFFFF);
        send_item(5'd19, 32'h1234_5678, 32'd7, 16'h1);              // unused codes
        send_item(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);

        // pause until everything is back
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);

        for (i = 0; i < 1650; i++) begin
            calm = (i >= 600 && i < 850);
            case ($urandom_range(0, 19))
                0, 1:    c = mia_pkg::CMD_MULT;
                2:       c = mia_pkg::CMD_DIV;
                3:       c = 5'($urandom_range(19, 31));
                default: c = 5'($urandom_range(0, 18));
            endcase
            if (c == mia_pkg::CMD_DIV && $urandom_range(0, 5) == 0)
                send_item(c, pick_word(), 32'd0, 16'($urandom));
            else
                send_item(c, pick_word(), pick_word(), 16'($urandom));
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
